### hdl/nm_sparsity_mask_builder_core_assert.svh
// Assertion macros for the N:M sparsity mask builder.
`ifndef NM_SPARSITY_MASK_BUILDER_CORE_ASSERT_SVH
`define NM_SPARSITY_MASK_BUILDER_CORE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define NMSM_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define NMSM_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define NMSM_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/nmsm_pkg.sv
// Shared constants and types of the N:M sparsity mask builder.
package nmsm_pkg;

	localparam int MAX_GROUP_DEF = 16;
	localparam int WEIGHT_W      = 32;
	localparam int MAG_W         = 31;
	localparam int CFG_W         = 5;
	localparam int MASK_W        = 16;
	localparam int GLEN_W        = 5;
	localparam int ADDR_W        = 3;
	localparam int DATA_W        = 32;

	localparam logic [CFG_W-1:0] KEEP_COUNT_RST = 5'd2;
	localparam logic [CFG_W-1:0] GROUP_SIZE_RST = 5'd4;

	// register index, taken from the upper address bit
	localparam logic REG_KEEP_COUNT = 1'b0;
	localparam logic REG_GROUP_SIZE = 1'b1;

	// broadcast to every cell: shift the chain and the magnitude being ranked
	typedef struct packed {
		logic             shift;
		logic [MAG_W-1:0] mag;
	} cell_bus_t;

endpackage

### hdl/nmsm_weight_if.sv
// Weight input channel.
interface nmsm_weight_if;
	logic                         valid;
	logic                         ready;
	logic [nmsm_pkg::WEIGHT_W-1:0] weight_bits;
	logic                         row_end;

	modport source (output valid, weight_bits, row_end, input ready);
	modport sink (input valid, weight_bits, row_end, output ready);
endinterface

### hdl/nmsm_mask_if.sv
// Mask result channel.
interface nmsm_mask_if;
	logic                        valid;
	logic                        ready;
	logic [nmsm_pkg::MASK_W-1:0] keep_mask;
	logic [nmsm_pkg::GLEN_W-1:0] group_length;
	logic                        closes_row;

	modport source (output valid, keep_mask, group_length, closes_row, input ready);
	modport sink (input valid, keep_mask, group_length, closes_row, output ready);
endinterface

### hdl/nm_sparsity_mask_builder_core.sv
// Top level of the N:M sparsity mask builder.
// Takes one float32 weight per cycle and ranks its magnitude (bits 30:0, unsigned) against
// the weights already buffered in its group as it arrives; a chain of MAX_GROUP cells holds
// the group, newest first, each cell keeping how many group members beat it. A group closes
// when it holds group_size weights (at most MAX_GROUP) or at a row end. Its keep mask passes
// through the s1 registers into the output register, which it enters unless a finished mask
// still waits there untaken. Input runs at one weight per cycle; it stalls only while a
// finished mask waits untaken in the output register and the next group has already closed.
// Each arrival is compared with every buffered magnitude, one compare per cell; the results are
// registered and then counted. There is no clearing pass after reset.
module nm_sparsity_mask_builder_core #(
	parameter int MAX_GROUP = nmsm_pkg::MAX_GROUP_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nmsm_pkg::ADDR_W-1:0]   paddr,
	input  logic [nmsm_pkg::DATA_W-1:0]   pwdata,
	output logic [nmsm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	nmsm_weight_if.sink                   wt,
	nmsm_mask_if.source                   mk
);

	localparam int CNT_W = $clog2(MAX_GROUP);
	localparam int LEN_W = $clog2(MAX_GROUP + 1);
	localparam int CMP_W = LEN_W + nmsm_pkg::CFG_W;

	logic [nmsm_pkg::CFG_W-1:0] keep_q;
	logic [nmsm_pkg::CFG_W-1:0] gsize_q;
	logic                       cfg_wr;

	logic                       accept;
	logic                       stall;
	logic                       take;
	logic [LEN_W-1:0]           fill_q;
	logic [LEN_W-1:0]           len_new;
	logic                       close_new;

	logic                       cls_s1;
	logic                       pend_s1;
	logic [LEN_W-1:0]           len_s1;
	logic                       row_s1;
	logic [MAX_GROUP-1:0]       gt_s1;

	logic [nmsm_pkg::MASK_W-1:0] mask_q;
	logic [nmsm_pkg::GLEN_W-1:0] glen_q;
	logic                        row_q;
	logic                        out_vld_q;

	nmsm_pkg::cell_bus_t        bus;
	logic [CNT_W-1:0]           pop;
	logic [CNT_W-1:0]           add0;
	logic [MAX_GROUP-1:0]       cmp_en;
	logic [MAX_GROUP-1:0]       gt;
	logic [MAX_GROUP-1:0]       kept;
	logic [MAX_GROUP-1:0]       mask_b;
	logic [nmsm_pkg::MASK_W-1:0] mask_d;
	logic [nmsm_pkg::MAG_W-1:0] mag      [MAX_GROUP];
	logic [CNT_W-1:0]           cnt_now  [MAX_GROUP];
	logic [CNT_W-1:0]           cnt_fwd  [MAX_GROUP];

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q  <= nmsm_pkg::KEEP_COUNT_RST;
			gsize_q <= nmsm_pkg::GROUP_SIZE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[nmsm_pkg::ADDR_W-1])
				nmsm_pkg::REG_KEEP_COUNT: keep_q  <= pwdata[nmsm_pkg::CFG_W-1:0];
				nmsm_pkg::REG_GROUP_SIZE: gsize_q <= pwdata[nmsm_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[nmsm_pkg::ADDR_W-1])
			nmsm_pkg::REG_KEEP_COUNT: prdata = nmsm_pkg::DATA_W'(keep_q);
			nmsm_pkg::REG_GROUP_SIZE: prdata = nmsm_pkg::DATA_W'(gsize_q);
			default:                  prdata = '0;
		endcase
	end

	// input side and group fill
	assign stall    = cls_s1 && out_vld_q && !mk.ready;
	assign take     = cls_s1 && !stall;
	assign wt.ready = !stall;
	assign accept   = wt.valid && wt.ready;
	assign len_new  = fill_q + LEN_W'(1);

	// group size zero acts as one, above MAX_GROUP saturates
	assign close_new = wt.row_end || (len_new == LEN_W'(MAX_GROUP)) ||
		(CMP_W'(len_new) >= CMP_W'(gsize_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			cls_s1  <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= accept;
			if (accept) begin
				fill_q <= close_new ? '0 : len_new;
				cls_s1 <= close_new;
			end else if (take) begin
				cls_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			len_s1 <= len_new;
			row_s1 <= wt.row_end;
			gt_s1  <= gt;
		end
	end

	// cell chain, cell 0 holds the newest weight
	assign bus.shift = accept;
	assign bus.mag   = wt.weight_bits[nmsm_pkg::MAG_W-1:0];
	// the newest entry picks up the count of older entries that beat it in the next cycle
	assign pop  = CNT_W'($countones(gt_s1));
	assign add0 = pend_s1 ? pop : '0;

	for (genvar k = 0; k < MAX_GROUP; k++) begin : g_cell
		logic [nmsm_pkg::MAG_W-1:0] prev_mag;
		logic [CNT_W-1:0]           prev_cnt;
		logic [CNT_W-1:0]           add;

		assign cmp_en[k] = accept && (LEN_W'(k) < fill_q);

		if (k == 0) begin : g_head
			assign prev_mag = bus.mag;
			assign prev_cnt = '0;
			assign add      = add0;
		end else begin : g_body
			assign prev_mag = mag[k-1];
			assign prev_cnt = cnt_fwd[k-1];
			assign add      = '0;
		end

		nmsm_cell #(
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.bus      (bus),
			.cmp_en   (cmp_en[k]),
			.add      (add),
			.prev_mag (prev_mag),
			.prev_cnt (prev_cnt),
			.mag      (mag[k]),
			.cnt_now  (cnt_now[k]),
			.cnt_fwd  (cnt_fwd[k]),
			.gt       (gt[k])
		);

		assign kept[k] = nmsm_pkg::CFG_W'(cnt_now[k]) < keep_q;
	end

	// position i of the group sits in cell len-1-i
	for (genvar i = 0; i < MAX_GROUP; i++) begin : g_mask
		logic [LEN_W-1:0] sel;

		assign sel       = len_s1 - LEN_W'(i + 1);
		assign mask_b[i] = (LEN_W'(i) < len_s1) && kept[sel[CNT_W-1:0]];
	end

	for (genvar b = 0; b < nmsm_pkg::MASK_W; b++) begin : g_out_bit
		if (b < MAX_GROUP) begin : g_live
			assign mask_d[b] = mask_b[b];
		end else begin : g_zero
			assign mask_d[b] = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take) begin
			out_vld_q <= 1'b1;
		end else if (mk.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mask_q <= mask_d;
			glen_q <= nmsm_pkg::GLEN_W'(len_s1);
			row_q  <= row_s1;
		end
	end

	assign mk.valid        = out_vld_q;
	assign mk.keep_mask    = mask_q;
	assign mk.group_length = glen_q;
	assign mk.closes_row   = row_q;

`include "nm_sparsity_mask_builder_core_assert.svh"

	`NMSM_CHECK(a_fill_below_max, fill_q < LEN_W'(MAX_GROUP), "fill count reached group limit")
	`NMSM_NEXT(a_close_reaches_s1, accept && close_new, cls_s1, "closed group lost before output")
	`NMSM_IMPLIES(a_fill_tracks_len, pend_s1 && !cls_s1, fill_q == len_s1, "fill count out of step")
	`NMSM_NEXT(a_stall_holds_group, stall, cls_s1 && out_vld_q, "stalled group dropped")

endmodule

### hdl/nmsm_cell.sv
// One rank cell: holds a buffered magnitude and the count of group members that beat it.
module nmsm_cell #(
	parameter int CNT_W = 4
) (
	input  logic                          clk,
	input  nmsm_pkg::cell_bus_t           bus,
	input  logic                          cmp_en,
	input  logic [CNT_W-1:0]              add,
	input  logic [nmsm_pkg::MAG_W-1:0]    prev_mag,
	input  logic [CNT_W-1:0]              prev_cnt,
	output logic [nmsm_pkg::MAG_W-1:0]    mag,
	output logic [CNT_W-1:0]              cnt_now,
	output logic [CNT_W-1:0]              cnt_fwd,
	output logic                          gt
);

	logic [nmsm_pkg::MAG_W-1:0] mag_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       ge;

	// a later arrival beats this entry on a tie
	assign ge      = cmp_en && (bus.mag >= mag_q);
	assign gt      = cmp_en && (mag_q > bus.mag);
	assign cnt_now = cnt_q + add;
	assign cnt_fwd = cnt_now + CNT_W'(ge);
	assign mag     = mag_q;

	always_ff @(posedge clk) begin
		if (bus.shift) begin
			mag_q <= prev_mag;
			cnt_q <= prev_cnt;
		end else begin
			cnt_q <= cnt_now;
		end
	end

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the N:M sparsity mask builder core.
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_GROUP   = nmsm_pkg::MAX_GROUP_DEF;
	localparam int DRAIN_PAD   = 6;
	localparam int END_WAIT    = 20000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 86;
	localparam int N_PHASES    = 14;

	typedef struct {
		logic [nmsm_pkg::MASK_W-1:0] keep_mask;
		logic [nmsm_pkg::GLEN_W-1:0] group_length;
		logic                        closes_row;
	} mask_result_t;

	// Tracks the open group and the masks still owed by the block.
	class mask_scoreboard;
		logic [nmsm_pkg::MAG_W-1:0] mags [MAX_GROUP];
		int unsigned                fill;
		logic [nmsm_pkg::CFG_W-1:0] keep_count;
		logic [nmsm_pkg::CFG_W-1:0] group_size;
		mask_result_t               owed_masks [$];
		int unsigned                n_weights;
		int unsigned                n_masks;
		int unsigned                n_errors;

		function new();
			fill       = 0;
			keep_count = nmsm_pkg::KEEP_COUNT_RST;
			group_size = nmsm_pkg::GROUP_SIZE_RST;
			n_weights  = 0;
			n_masks    = 0;
			n_errors   = 0;
		endfunction

		function int pending();
			return owed_masks.size();
		endfunction

		// Keep an element when fewer than keep_count members beat it; ties go to the later one.
		function logic [nmsm_pkg::MASK_W-1:0] group_keep_mask(int unsigned len);
			logic [nmsm_pkg::MASK_W-1:0] m;
			int unsigned                 beaten;
			m = '0;
			for (int i = 0; i < len; i++) begin
				beaten = 0;
				for (int j = 0; j < len; j++)
					if (j != i && (mags[j] > mags[i] || (mags[j] == mags[i] && j > i)))
						beaten++;
				if (beaten < keep_count && i < nmsm_pkg::MASK_W)
					m[i] = 1'b1;
			end
			return m;
		endfunction

		function void note_weight(logic [nmsm_pkg::WEIGHT_W-1:0] w, logic re);
			int unsigned  len;
			int unsigned  eff;
			mask_result_t r;
			n_weights++;
			if (fill < MAX_GROUP) begin
				mags[fill] = w[nmsm_pkg::MAG_W-1:0];
				fill++;
			end else begin
				mags[MAX_GROUP-1] = w[nmsm_pkg::MAG_W-1:0];
			end
			len = fill;
			eff = (group_size == 0) ? 1 : ((group_size > MAX_GROUP) ? MAX_GROUP : group_size);
			if (!re && len < eff)
				return;
			r.keep_mask    = group_keep_mask(len);
			r.group_length = nmsm_pkg::GLEN_W'(len);
			r.closes_row   = re;
			owed_masks     = {owed_masks, r};
			fill = 0;
		endfunction

		function void check_mask(logic [nmsm_pkg::MASK_W-1:0] m,
			logic [nmsm_pkg::GLEN_W-1:0] len, logic cr);
			mask_result_t e;
			n_masks++;
			if (owed_masks.size() == 0) begin
				n_errors++;
				$display("%0t: expected no mask, got mask %h len %0d row %0b",
					$time, m, len, cr);
				return;
			end
			e = owed_masks.pop_front();
			if (e.keep_mask !== m || e.group_length !== len || e.closes_row !== cr) begin
				n_errors++;
				$display("%0t: expected mask %h len %0d row %0b, got mask %h len %0d row %0b",
					$time, e.keep_mask, e.group_length, e.closes_row, m, len, cr);
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [nmsm_pkg::ADDR_W-1:0] paddr;
	logic [nmsm_pkg::DATA_W-1:0] pwdata;
	logic [nmsm_pkg::DATA_W-1:0] prdata;
	logic                        pready;

	nmsm_weight_if wt_if ();
	nmsm_mask_if   mk_if ();

	nm_sparsity_mask_builder_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.wt      (wt_if),
		.mk      (mk_if)
	);

	mask_scoreboard sb = new();

	bit tx_gaps;
	bit rx_random;
	bit hold_req;
	int n_settings;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("nm_sparsity_mask_builder_core: mismatch");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (!tx_gaps || hold_req)
			return 0;
		r = $urandom_range(0, 15);
		if (r < 9)
			return 0;
		if (r < 14)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Mix of raw patterns, specials, near-equal values and a small pool to force ties.
	function automatic logic [nmsm_pkg::WEIGHT_W-1:0] rand_weight();
		logic [nmsm_pkg::MAG_W-1:0] pool [4];
		logic [nmsm_pkg::MAG_W-1:0] specials [6];
		logic                       sgn;
		pool     = '{31'h3F800000, 31'h3F800001, 31'h00000000, 31'h7FC00000};
		specials = '{31'h00000000, 31'h3F800000, 31'h7F800000, 31'h7FC00000,
			31'h7FFFFFFF, 31'h00000001};
		sgn = 1'($urandom_range(0, 1));
		unique case ($urandom_range(0, 7))
			0, 1, 2: begin
				return $urandom();
			end
			3, 4: begin
				return {sgn, pool[2'($urandom_range(0, 3))]};
			end
			5: begin
				return {sgn, specials[3'($urandom_range(0, 5))]};
			end
			default: begin
				return {sgn, 8'($urandom_range(124, 130)), 23'($urandom_range(0, 7))};
			end
		endcase
	endfunction

	task automatic send_weight(input logic [nmsm_pkg::WEIGHT_W-1:0] w, input logic re);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			wt_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		wt_if.valid       <= 1'b1;
		wt_if.weight_bits <= w;
		wt_if.row_end     <= re;
		do @(posedge clk); while (!wt_if.ready);
		sb.note_weight(w, re);
	endtask

	// Drop valid, wait for every owed mask, then give the pipeline time to empty.
	task automatic settle();
		wt_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input logic reg_sel, input logic [nmsm_pkg::CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= nmsm_pkg::DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == nmsm_pkg::REG_KEEP_COUNT)
			sb.keep_count = value;
		else
			sb.group_size = value;
	endtask

	task automatic configure(input logic [nmsm_pkg::CFG_W-1:0] keep,
		input logic [nmsm_pkg::CFG_W-1:0] grp);
		settle();
		write_reg(nmsm_pkg::REG_KEEP_COUNT, keep);
		write_reg(nmsm_pkg::REG_GROUP_SIZE, grp);
		n_settings++;
	endtask

	// Result side: check each transfer, then pick the next ready level.
	initial begin
		int rx_wait;
		int hold_cnt;
		rx_wait  = 0;
		hold_cnt = 0;
		mk_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && mk_if.valid && mk_if.ready)
				sb.check_mask(mk_if.keep_mask, mk_if.group_length, mk_if.closes_row);
			if (hold_req) begin
				if (hold_cnt < HOLD_CYCLES) begin
					hold_cnt++;
					mk_if.ready <= 1'b0;
				end else begin
					hold_cnt = 0;
					hold_req = 1'b0;
					mk_if.ready <= 1'b1;
				end
			end else if (rx_wait > 0) begin
				rx_wait--;
				mk_if.ready <= 1'b0;
			end else if (rx_random && $urandom_range(0, 3) == 0) begin
				rx_wait = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
				mk_if.ready <= 1'b0;
			end else begin
				mk_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [nmsm_pkg::CFG_W-1:0] keep_tab [12];
		logic [nmsm_pkg::CFG_W-1:0] grp_tab  [12];
		logic [nmsm_pkg::CFG_W-1:0] keep;
		logic [nmsm_pkg::CFG_W-1:0] grp;
		int                         wait_cnt;
		keep_tab = '{5'd2, 5'd0, 5'd16, 5'd1, 5'd3, 5'd8, 5'd2, 5'd15, 5'd1, 5'd4, 5'd6, 5'd2};
		grp_tab  = '{5'd4, 5'd1, 5'd16, 5'd16, 5'd31, 5'd8, 5'd0, 5'd16, 5'd2, 5'd5, 5'd12,
			5'd3};
		n_settings = 0;
		tx_gaps    = 1'b1;
		rx_random  = 1'b1;
		hold_req   = 1'b0;
		arst_n     = 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		wt_if.valid       <= 1'b0;
		wt_if.weight_bits <= '0;
		wt_if.row_end     <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: zero vs negative zero tie, NaN patterns at the top
		send_weight(32'h00000000, 1'b0);
		send_weight(32'h80000000, 1'b0);
		send_weight(32'h7FFFFFFF, 1'b0);
		send_weight(32'hFFFFFFFF, 1'b0);
		send_weight(32'h3F800000, 1'b0);
		send_weight(32'hBF800000, 1'b0);
		send_weight(32'h7F800000, 1'b0);
		send_weight(32'hFF7FFFFF, 1'b0);
		// row end cuts groups short
		send_weight(32'h12345678, 1'b0);
		send_weight(32'h40000000, 1'b1);
		send_weight(32'hC0000000, 1'b1);
		// nothing kept
		configure(5'd0, 5'd3);
		repeat (3) send_weight(rand_weight(), 1'b0);
		// keep count covers the whole group
		configure(5'd16, 5'd5);
		send_weight(32'h3F800000, 1'b0);
		send_weight(32'h3F800000, 1'b0);
		send_weight(32'h00000001, 1'b1);
		// group size zero acts as one
		configure(5'd1, 5'd0);
		send_weight(32'hAAAAAAAA, 1'b0);
		send_weight(32'h55555555, 1'b0);
		// shrink the group while three weights sit in it
		configure(5'd2, 5'd8);
		repeat (3) send_weight(rand_weight(), 1'b0);
		configure(5'd2, 5'd2);
		send_weight(32'h3F800000, 1'b0);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph < 12) begin
				keep = keep_tab[ph];
				grp  = grp_tab[ph];
			end else begin
				keep = nmsm_pkg::CFG_W'($urandom_range(0, 16));
				grp  = nmsm_pkg::CFG_W'($urandom_range(0, 16));
			end
			configure(keep, grp);
			tx_gaps   = (ph % 4 != 3);
			rx_random = (ph % 4 != 3);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// stall the result side while weights keep coming
				if (ph == 0 && k == 20)
					hold_req = 1'b1;
				send_weight(rand_weight(), $urandom_range(0, 9) == 0);
			end
		end

		wt_if.valid <= 1'b0;
		wait_cnt = 0;
		while (sb.pending() != 0 && wait_cnt < END_WAIT) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (DRAIN_PAD) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.n_errors++;
			$display("%0t: %0d masks never arrived", $time, sb.pending());
		end
		$display("Ran %0d weights into %0d masks across %0d register settings,",
			sb.n_weights, sb.n_masks, n_settings);
		$display("with ties, NaN and zero patterns, early row ends and a long output stall.");
		if (sb.n_errors == 0) begin
			$display("nm_sparsity_mask_builder_core: match");
		end else begin
			$display("nm_sparsity_mask_builder_core: mismatch");
		end
		$finish;
	end

endmodule
